### src/jmbh_pkg.sv
// ----------------------------------------------------------------------------
// jmbh_pkg
// Types, constants and mix functions shared by the byte hash modules.
// ----------------------------------------------------------------------------
`default_nettype none

package jmbh_pkg;

    localparam logic [31:0] GOLDEN_RATIO = 32'h9E37_79B9;
    localparam int          QUEUE_DEPTH  = 4;
    localparam int          QPTR_W       = $clog2(QUEUE_DEPTH);

    localparam logic [1:0] LANE_A = 2'd0;
    localparam logic [1:0] LANE_B = 2'd1;
    localparam logic [1:0] LANE_C = 2'd2;

    localparam logic [1:0] ROUND_FIRST = 2'd0;
    localparam logic [1:0] ROUND_LAST  = 2'd2;

    localparam logic [2:0] FULL_WORD_BYTES = 3'd4;

    typedef struct packed {
        logic [31:0] add_val;
        logic [1:0]  add_lane;
        logic        block_mix;
        logic        last;
        logic        start;
        logic [31:0] total;
    } t_op;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
    } t_lanes;

    typedef enum logic [1:0] {
        S_ADD,
        S_MIX,
        S_TOTAL
    } t_bstate;

    function automatic t_lanes mix_rows(t_lanes l, int unsigned sa, int unsigned sb,
                                        int unsigned sc);
        t_lanes r;
        r   = l;
        r.a = (r.a - r.b - r.c) ^ (r.c >> sa);
        r.b = (r.b - r.c - r.a) ^ (r.a << sb);
        r.c = (r.c - r.a - r.b) ^ (r.b >> sc);
        return r;
    endfunction

    function automatic t_lanes mix_round(t_lanes l, logic [1:0] rnd);
        t_lanes r;
        case (rnd)
            2'd0: begin
                r = mix_rows(l, 13, 8, 13);
            end
            2'd1: begin
                r = mix_rows(l, 12, 16, 5);
            end
            default: begin
                r = mix_rows(l, 3, 10, 15);
            end
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

### src/jmbh_front.sv
// ----------------------------------------------------------------------------
// jmbh_front
// Accepts key words, tracks key position and turns each word into an operation.
// ----------------------------------------------------------------------------
`default_nettype none

module jmbh_front import jmbh_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire logic [31:0] i_word,
    input  wire logic [2:0]  i_count,
    input  wire logic        i_last,
    output      logic        o_ready,
    input  wire logic        i_q_full,
    output      logic        o_push,
    output      t_op         o_op
);

    logic        r_in_key;
    logic [1:0]  r_word_slot;
    logic [31:0] r_total;
    logic        n_in_key;
    logic [1:0]  n_word_slot;
    logic [31:0] n_total;

    logic [2:0]  count;
    logic        full;
    logic        start;
    logic [1:0]  slot;
    logic [31:0] mask;
    logic [31:0] masked;
    logic [31:0] total;

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;

    always_comb begin
        count = (!i_last || i_count > FULL_WORD_BYTES) ? FULL_WORD_BYTES : i_count;
        full  = (count == FULL_WORD_BYTES);
        start = !r_in_key;
        slot  = start ? LANE_A : r_word_slot;
        total = (start ? 32'd0 : r_total) + {29'd0, count};
        case (count)
            3'd0:    mask = 32'h0000_0000;
            3'd1:    mask = 32'h0000_00FF;
            3'd2:    mask = 32'h0000_FFFF;
            3'd3:    mask = 32'h00FF_FFFF;
            default: mask = 32'hFFFF_FFFF;
        endcase
        masked = i_word & mask;

        o_op.add_lane  = slot;
        o_op.add_val   = (slot == LANE_C && !full) ? {masked[23:0], 8'h00} : masked;
        o_op.block_mix = full && (slot == LANE_C);
        o_op.last      = i_last;
        o_op.start     = start;
        o_op.total     = total;

        n_in_key    = !i_last;
        n_word_slot = (i_last || slot == LANE_C) ? LANE_A : slot + 2'd1;
        n_total     = i_last ? 32'd0 : total;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_key    <= 1'b0;
            r_word_slot <= LANE_A;
            r_total     <= 32'd0;
        end else if (o_push) begin
            r_in_key    <= n_in_key;
            r_word_slot <= n_word_slot;
            r_total     <= n_total;
        end
    end

endmodule

`default_nettype wire

### src/jmbh_queue.sv
// ----------------------------------------------------------------------------
// jmbh_queue
// Short first-in first-out queue of operations between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module jmbh_queue import jmbh_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_op  i_op,
    output      logic o_full,
    input  wire logic i_pop,
    output      logic o_valid,
    output      t_op  o_op
);

    t_op                r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QPTR_W:0]    r_count;
    logic               push;
    logic               pop;

    assign o_full  = (r_count == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_op    = r_mem[r_rd_ptr];
    assign push    = i_push && !o_full;
    assign pop     = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

### src/jmbh_back.sv
// ----------------------------------------------------------------------------
// jmbh_back
// Holds the three lanes, applies each operation and runs the mix in rounds.
// ----------------------------------------------------------------------------
`default_nettype none

module jmbh_back import jmbh_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [31:0] i_seed,
    input  wire logic        i_op_valid,
    input  wire t_op         i_op,
    output      logic        o_pop,
    output      logic        o_valid,
    output      logic [31:0] o_hash,
    input  wire logic        i_ready
);

    t_bstate     r_state;
    t_bstate     n_state;
    t_lanes      r_lanes;
    t_lanes      n_lanes;
    logic [1:0]  r_round;
    logic [1:0]  n_round;
    logic        r_final;
    logic        n_final;
    t_op         r_op;
    t_op         n_op;
    logic        r_out_valid;
    logic [31:0] r_hash;

    t_lanes      base;
    t_lanes      mixed;
    logic        out_free;
    logic        round_end;
    logic        stall;
    logic        load_out;

    assign out_free  = !r_out_valid || i_ready;
    assign round_end = (r_round == ROUND_LAST);
    assign stall     = r_final && round_end && !out_free;
    assign mixed     = mix_round(r_lanes, r_round);
    assign o_valid   = r_out_valid;
    assign o_hash    = r_hash;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_ADD: begin
                if (i_op_valid && (i_op.block_mix || i_op.last)) begin
                    n_state = S_MIX;
                end
            end
            S_MIX: begin
                if (round_end && !stall) begin
                    n_state = (!r_final && r_op.last) ? S_TOTAL : S_ADD;
                end
            end
            S_TOTAL: begin
                n_state = S_MIX;
            end
            default: begin
                n_state = S_ADD;
            end
        endcase
    end

    always_comb begin
        n_lanes  = r_lanes;
        n_round  = r_round;
        n_final  = r_final;
        n_op     = r_op;
        o_pop    = 1'b0;
        load_out = 1'b0;
        base     = i_op.start ? t_lanes'{a: GOLDEN_RATIO, b: GOLDEN_RATIO, c: i_seed}
                              : r_lanes;
        case (r_state)
            S_ADD: begin
                o_pop = i_op_valid;
                if (i_op_valid) begin
                    n_lanes = base;
                    case (i_op.add_lane)
                        LANE_A:  n_lanes.a = base.a + i_op.add_val;
                        LANE_B:  n_lanes.b = base.b + i_op.add_val;
                        default: n_lanes.c = base.c + i_op.add_val;
                    endcase
                    if (i_op.last && !i_op.block_mix) begin
                        n_lanes.c = n_lanes.c + i_op.total;
                    end
                    n_op    = i_op;
                    n_round = ROUND_FIRST;
                    n_final = !i_op.block_mix;
                end
            end
            S_MIX: begin
                if (!stall) begin
                    n_lanes  = mixed;
                    n_round  = round_end ? ROUND_FIRST : r_round + 2'd1;
                    load_out = r_final && round_end;
                end
            end
            S_TOTAL: begin
                n_lanes.c = r_lanes.c + r_op.total;
                n_final   = 1'b1;
                n_round   = ROUND_FIRST;
            end
            default: begin
                n_round = ROUND_FIRST;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_lanes <= n_lanes;
        r_op    <= n_op;
        if (load_out) begin
            r_hash <= mixed.c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_ADD;
            r_round     <= ROUND_FIRST;
            r_final     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_round <= n_round;
            r_final <= n_final;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

### src/jenkins_mix_byte_hash.sv
// ----------------------------------------------------------------------------
// jenkins_mix_byte_hash
// Lookup2 32-bit hash over keys delivered as little-endian words.
// ----------------------------------------------------------------------------
// Channel   Direction  Transaction
// s_axis    in         one key word; tlast marks the final word of the key
// m_axis    out        one 32-bit hash for each completed key
// seed      in         write of the seed that lane c starts from for each key
//
// In the back end a word that does not close a 12-byte block is only added;
// a word that closes a block is added and then mixed in three rounds. The
// final word is added and mixed in three rounds too, then, if it closed a
// block, the total is added and three more rounds follow. A mix round is
// three dependent rows of subtract and xor. Reset is synchronous and active
// low; a four-entry queue lets the input run ahead, and a stalled output holds only the final mix round.
// ----------------------------------------------------------------------------
`default_nettype none

module jenkins_mix_byte_hash import jmbh_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_seed_we,
    input  wire logic [31:0] i_seed,
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    // Fields from bit 0: data_word[31:0], bytes_valid[34:32], zero fill.
    input  wire logic [39:0] s_axis_tdata,
    input  wire logic        s_axis_tlast,
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // Fields from bit 0: hash_value[31:0].
    output      logic [31:0] m_axis_tdata
);

    logic [31:0] r_seed;
    logic        push;
    logic        q_full;
    logic        q_valid;
    logic        pop;
    t_op         front_op;
    t_op         q_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= 32'd0;
        end else if (i_seed_we) begin
            r_seed <= i_seed;
        end
    end

    jmbh_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .i_word   (s_axis_tdata[31:0]),
        .i_count  (s_axis_tdata[34:32]),
        .i_last   (s_axis_tlast),
        .o_ready  (s_axis_tready),
        .i_q_full (q_full),
        .o_push   (push),
        .o_op     (front_op)
    );

    jmbh_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (front_op),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_op    (q_op)
    );

    jmbh_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_seed     (r_seed),
        .i_op_valid (q_valid),
        .i_op       (q_op),
        .o_pop      (pop),
        .o_valid    (m_axis_tvalid),
        .o_hash     (m_axis_tdata),
        .i_ready    (m_axis_tready)
    );

endmodule

`default_nettype wire
